// ----- design/i2cm_pkg.sv -----
`default_nettype none

package i2cm_pkg;

    localparam int BUFFER_DEPTH_DEF = 256;

    // operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_EVENT = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_BUSY  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // bus commands
    localparam logic [1:0] CMD_NONE    = 2'd0;
    localparam logic [1:0] CMD_START   = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;
    localparam logic [1:0] CMD_STOP    = 2'd3;

    localparam logic READ_BIT = 1'b1;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] buffer_index;
        logic [7:0] buffer_byte;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] length;
        logic       read_mode;
        logic       ack_missing;
        logic [7:0] data_in;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] bus_command;
        logic       write_strobe;
        logic [7:0] write_byte;
        logic       mem_sel;
        logic       read_strobe;
        logic       transmit_dir;
        logic       nack_next;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [7:0] rx_index;
    } result_t;

    typedef struct packed {
        logic       wr_en;
        logic [7:0] wr_pos;
        logic [7:0] wr_data;
        logic       rd_en;
        logic [7:0] rd_pos;
    } mem_req_t;

endpackage

`default_nettype wire

// ----- design/i2cm_if.sv -----
`default_nettype none

interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] buffer_index;
    logic [7:0] buffer_byte;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] length;
    logic       read_mode;
    logic       ack_missing;
    logic [7:0] data_in;

    modport source (
        output valid, operation, buffer_index, buffer_byte, device_address,
               register_address, length, read_mode, ack_missing, data_in,
        input  ready
    );
    modport sink (
        input  valid, operation, buffer_index, buffer_byte, device_address,
               register_address, length, read_mode, ack_missing, data_in,
        output ready
    );
endinterface

interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [1:0] bus_command;
    logic       write_strobe;
    logic [7:0] write_byte;
    logic       read_strobe;
    logic       transmit_dir;
    logic       nack_next;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;

    modport source (
        output valid, status, bus_command, write_strobe, write_byte, read_strobe,
               transmit_dir, nack_next, rx_valid, rx_byte, rx_index,
        input  ready
    );
    modport sink (
        input  valid, status, bus_command, write_strobe, write_byte, read_strobe,
               transmit_dir, nack_next, rx_valid, rx_byte, rx_index,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/i2c_master_register_transaction.sv -----
`default_nettype none

// register-addressed i2c read/write sequencer. each accepted word (buffer load,
// start, byte-complete event, or the unused code) gives exactly one result
// word, valid on the cycle after acceptance. a new word is taken every cycle
// while the result register is empty or being drained, so the sustained rate
// is one word per clock; it is set by the single result register and the
// registered read of the write-buffer ram, which is written and read once per
// cycle. the buffer has no reset and no clearing pass: reading an entry that
// was never loaded or received gives an arbitrary byte.
module i2c_master_register_transaction
    import i2cm_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    i2cm_in_if.sink   in_ch,
    i2cm_out_if.source out_ch
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    in_word_t   in_word;
    result_t    result;
    mem_req_t   mem_req;
    logic       accept;
    logic [7:0] rd_data;

    result_t    res_reg;
    logic       out_valid_reg, out_valid_next;

    assign in_word.operation        = in_ch.operation;
    assign in_word.buffer_index     = in_ch.buffer_index;
    assign in_word.buffer_byte      = in_ch.buffer_byte;
    assign in_word.device_address   = in_ch.device_address;
    assign in_word.register_address = in_ch.register_address;
    assign in_word.length           = in_ch.length;
    assign in_word.read_mode        = in_ch.read_mode;
    assign in_word.ack_missing      = in_ch.ack_missing;
    assign in_word.data_in          = in_ch.data_in;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    i2cm_seq #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .in_word(in_word),
        .result (result),
        .mem_req(mem_req)
    );

    i2cm_buffer #(
        .DEPTH(BUFFER_DEPTH),
        .AW   (AW)
    ) u_buffer (
        .clk    (clk),
        .wr_en  (mem_req.wr_en),
        .wr_addr(mem_req.wr_pos[AW-1:0]),
        .wr_data(mem_req.wr_data),
        .rd_en  (mem_req.rd_en),
        .rd_addr(mem_req.rd_pos[AW-1:0]),
        .rd_data(rd_data)
    );

    assign out_valid_next = accept || (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= result;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = res_reg.status;
    assign out_ch.bus_command  = res_reg.bus_command;
    assign out_ch.write_strobe = res_reg.write_strobe;
    assign out_ch.write_byte   = res_reg.mem_sel ? rd_data : res_reg.write_byte;
    assign out_ch.read_strobe  = res_reg.read_strobe;
    assign out_ch.transmit_dir = res_reg.transmit_dir;
    assign out_ch.nack_next    = res_reg.nack_next;
    assign out_ch.rx_valid     = res_reg.rx_valid;
    assign out_ch.rx_byte      = res_reg.rx_byte;
    assign out_ch.rx_index     = res_reg.rx_index;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted word produced no result");

    a_rx_reads_reg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.rx_valid |-> res_reg.read_strobe && !res_reg.write_strobe)
        else $error("received byte without data register read");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.bus_command == CMD_START
            |-> res_reg.write_strobe && res_reg.status == ST_BUSY && res_reg.transmit_dir)
        else $error("start without address byte or busy status");

    a_buffer_byte_sent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_reg.mem_sel |-> res_reg.write_strobe && !res_reg.read_strobe)
        else $error("buffer byte selected outside a data transmit");

endmodule

`default_nettype wire

// ----- design/i2cm_buffer.sv -----
`default_nettype none

module i2cm_buffer #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds when not enabled, so a stalled result keeps its byte
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- design/i2cm_seq.sv -----
`default_nettype none

module i2cm_seq
    import i2cm_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire in_word_t in_word,
    output result_t       result,
    output mem_req_t      mem_req
);

    localparam logic [8:0] DEPTH_W = 9'(BUFFER_DEPTH);

    logic [7:0] byte_position_reg, byte_position_next;
    logic       dir_transmit_reg, dir_transmit_next;
    logic       nack_setting_reg, nack_setting_next;
    logic [1:0] status_reg, status_next;
    logic [6:0] target_addr_reg, target_addr_next;
    logic [7:0] target_register_reg, target_register_next;
    logic [7:0] byte_count_reg, byte_count_next;
    logic       is_read_reg, is_read_next;
    logic       register_sent_reg, register_sent_next;
    logic       restart_sent_reg, restart_sent_next;

    logic [8:0] pos_w;
    logic [8:0] cnt_w;
    logic       pos_in_range;
    logic       idx_in_range;

    assign pos_w        = {1'b0, byte_position_reg};
    assign cnt_w        = {1'b0, byte_count_reg};
    assign pos_in_range = pos_w < DEPTH_W;
    assign idx_in_range = {1'b0, in_word.buffer_index} < DEPTH_W;

    always_comb
    begin
        byte_position_next   = byte_position_reg;
        dir_transmit_next    = dir_transmit_reg;
        nack_setting_next    = nack_setting_reg;
        status_next          = status_reg;
        target_addr_next     = target_addr_reg;
        target_register_next = target_register_reg;
        byte_count_next      = byte_count_reg;
        is_read_next         = is_read_reg;
        register_sent_next   = register_sent_reg;
        restart_sent_next    = restart_sent_reg;

        result             = '0;
        mem_req            = '0;
        mem_req.rd_en      = accept;
        mem_req.rd_pos     = byte_position_reg;
        mem_req.wr_pos     = byte_position_reg;
        mem_req.wr_data    = in_word.data_in;

        unique case (in_word.operation)
            OP_LOAD:
            begin
                mem_req.wr_en   = accept && idx_in_range;
                mem_req.wr_pos  = in_word.buffer_index;
                mem_req.wr_data = in_word.buffer_byte;
            end
            OP_START:
            begin
                if (in_word.length != 8'd0)
                begin
                    target_addr_next     = in_word.device_address;
                    target_register_next = in_word.register_address;
                    byte_count_next      = in_word.length;
                    byte_position_next   = 8'd0;
                    register_sent_next   = 1'b0;
                    restart_sent_next    = 1'b0;
                    is_read_next         = in_word.read_mode;
                end
                dir_transmit_next   = 1'b1;
                result.bus_command  = CMD_START;
                result.write_strobe = 1'b1;
                result.write_byte   = {target_addr_next, 1'b0};
                status_next         = ST_BUSY;
            end
            OP_EVENT:
            begin
                if (dir_transmit_reg)
                begin
                    if (in_word.ack_missing)
                    begin
                        if (is_read_reg || pos_w <= cnt_w)
                        begin
                            status_next        = ST_ERROR;
                            result.bus_command = CMD_STOP;
                        end
                    end
                    else if (!is_read_reg)
                    begin
                        if (pos_w < cnt_w)
                        begin
                            result.write_strobe = 1'b1;
                            if (!register_sent_reg)
                            begin
                                result.write_byte  = target_register_reg;
                                register_sent_next = 1'b1;
                            end
                            else
                            begin
                                // data byte comes from the buffer read registered on this accept
                                result.mem_sel     = pos_in_range;
                                byte_position_next = byte_position_reg + 8'd1;
                            end
                        end
                        else if (pos_w == cnt_w)
                        begin
                            status_next        = ST_DONE;
                            result.bus_command = CMD_STOP;
                        end
                    end
                    else if (!register_sent_reg)
                    begin
                        result.write_strobe = 1'b1;
                        result.write_byte   = target_register_reg;
                        register_sent_next  = 1'b1;
                    end
                    else if (!restart_sent_reg)
                    begin
                        result.bus_command  = CMD_RESTART;
                        result.write_strobe = 1'b1;
                        result.write_byte   = {target_addr_reg, READ_BIT};
                        restart_sent_next   = 1'b1;
                    end
                    else
                    begin
                        dir_transmit_next  = 1'b0;
                        nack_setting_next  = byte_count_reg == 8'd1;
                        result.read_strobe = 1'b1;
                    end
                end
                else if (cnt_w != 9'd0 && pos_w + 9'd1 <= cnt_w)
                begin
                    // receive a byte; last one ends the transfer
                    result.read_strobe = 1'b1;
                    result.rx_valid    = 1'b1;
                    result.rx_byte     = in_word.data_in;
                    result.rx_index    = byte_position_reg;
                    mem_req.wr_en      = accept && pos_in_range;
                    byte_position_next = byte_position_reg + 8'd1;
                    if (pos_w + 9'd1 == cnt_w)
                    begin
                        dir_transmit_next  = 1'b1;
                        result.bus_command = CMD_STOP;
                        status_next        = ST_DONE;
                    end
                    else
                    begin
                        nack_setting_next = pos_w + 9'd2 == cnt_w;
                    end
                end
            end
            default:
            begin
            end
        endcase

        result.status       = status_next;
        result.transmit_dir = dir_transmit_next;
        result.nack_next    = nack_setting_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg   <= '0;
            dir_transmit_reg    <= 1'b0;
            nack_setting_reg    <= 1'b0;
            status_reg          <= ST_DONE;
            target_addr_reg     <= '0;
            target_register_reg <= '0;
            byte_count_reg      <= '0;
            is_read_reg         <= 1'b0;
            register_sent_reg   <= 1'b0;
            restart_sent_reg    <= 1'b0;
        end
        else if (accept)
        begin
            byte_position_reg   <= byte_position_next;
            dir_transmit_reg    <= dir_transmit_next;
            nack_setting_reg    <= nack_setting_next;
            status_reg          <= status_next;
            target_addr_reg     <= target_addr_next;
            target_register_reg <= target_register_next;
            byte_count_reg      <= byte_count_next;
            is_read_reg         <= is_read_next;
            register_sent_reg   <= register_sent_next;
            restart_sent_reg    <= restart_sent_next;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/i2cm_reply_check_pkg.sv -----
`timescale 1ns / 1ps

package i2cm_reply_check_pkg;

    import i2cm_pkg::*;

    // the one code the block treats as a no-op
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] bus_command;
        logic       write_strobe;
        logic [7:0] write_byte;
        logic       read_strobe;
        logic       transmit_dir;
        logic       nack_next;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [7:0] rx_index;
    } reply_t;

    class transaction_scoreboard;
        logic [7:0] buf_mem [BUFFER_DEPTH_DEF];
        bit         buf_known [BUFFER_DEPTH_DEF];
        logic [7:0] position;
        logic       dir_tx;
        logic       nack_set;
        logic [1:0] status_q;
        logic [6:0] target;
        logic [7:0] target_reg;
        logic [7:0] count;
        logic       is_read;
        logic       reg_sent;
        logic       restart_sent;
        reply_t     replies_due [$];
        int         mismatches;

        function new();
            position     = '0;
            dir_tx       = 1'b0;
            nack_set     = 1'b0;
            status_q     = ST_DONE;
            target       = '0;
            target_reg   = '0;
            count        = '0;
            is_read      = 1'b0;
            reg_sent     = 1'b0;
            restart_sent = 1'b0;
            mismatches   = 0;
        endfunction

        function void store(logic [7:0] idx, logic [7:0] data);
            if (int'(idx) < BUFFER_DEPTH_DEF)
            begin
                buf_mem[idx]   = data;
                buf_known[idx] = 1'b1;
            end
        endfunction

        // true when this word would send a buffer entry that was never written
        function bit needs_fill(in_word_t w);
            return w.operation == OP_EVENT && dir_tx && !w.ack_missing && !is_read
                && reg_sent && position < count && !buf_known[position];
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function void note_word(in_word_t w);
            reply_t r;
            int     pos;
            int     cnt;
            r   = '0;
            pos = int'(position);
            cnt = int'(count);
            case (w.operation)
                OP_LOAD:
                begin
                    store(w.buffer_index, w.buffer_byte);
                end
                OP_START:
                begin
                    // length 0 reruns the previous transaction from where it stopped
                    if (w.length != 8'd0)
                    begin
                        target       = w.device_address;
                        target_reg   = w.register_address;
                        count        = w.length;
                        position     = '0;
                        reg_sent     = 1'b0;
                        restart_sent = 1'b0;
                        is_read      = w.read_mode;
                    end
                    dir_tx         = 1'b1;
                    r.bus_command  = CMD_START;
                    r.write_strobe = 1'b1;
                    r.write_byte   = {target, 1'b0};
                    status_q       = ST_BUSY;
                end
                OP_EVENT:
                begin
                    if (dir_tx)
                    begin
                        if (w.ack_missing)
                        begin
                            if (is_read || pos <= cnt)
                            begin
                                status_q      = ST_ERROR;
                                r.bus_command = CMD_STOP;
                            end
                        end
                        else if (!is_read)
                        begin
                            if (pos < cnt)
                            begin
                                r.write_strobe = 1'b1;
                                if (!reg_sent)
                                begin
                                    r.write_byte = target_reg;
                                    reg_sent     = 1'b1;
                                end
                                else
                                begin
                                    r.write_byte = buf_mem[position];
                                    position     = position + 8'd1;
                                end
                            end
                            else if (pos == cnt)
                            begin
                                status_q      = ST_DONE;
                                r.bus_command = CMD_STOP;
                            end
                        end
                        else if (!reg_sent)
                        begin
                            r.write_strobe = 1'b1;
                            r.write_byte   = target_reg;
                            reg_sent       = 1'b1;
                        end
                        else if (!restart_sent)
                        begin
                            r.bus_command  = CMD_RESTART;
                            r.write_strobe = 1'b1;
                            r.write_byte   = {target, READ_BIT};
                            restart_sent   = 1'b1;
                        end
                        else
                        begin
                            // turn the bus around, nack ahead when only one byte comes
                            dir_tx        = 1'b0;
                            nack_set      = (count == 8'd1);
                            r.read_strobe = 1'b1;
                        end
                    end
                    else if (pos == cnt - 1)
                    begin
                        dir_tx        = 1'b1;
                        r.read_strobe = 1'b1;
                        r.rx_valid    = 1'b1;
                        r.rx_byte     = w.data_in;
                        r.rx_index    = position;
                        store(position, w.data_in);
                        r.bus_command = CMD_STOP;
                        position      = position + 8'd1;
                        status_q      = ST_DONE;
                    end
                    else if (pos < cnt - 1)
                    begin
                        nack_set      = (pos == cnt - 2);
                        r.read_strobe = 1'b1;
                        r.rx_valid    = 1'b1;
                        r.rx_byte     = w.data_in;
                        r.rx_index    = position;
                        store(position, w.data_in);
                        position      = position + 8'd1;
                    end
                end
                default:
                begin
                end
            endcase
            r.status       = status_q;
            r.transmit_dir = dir_tx;
            r.nack_next    = nack_set;
            replies_due.push_back(r);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (replies_due.size() == 0)
            begin
                $error("result word with nothing expected");
                mismatches++;
                return;
            end
            want = replies_due.pop_front();
            check_field("status", want.status, got.status);
            check_field("bus_command", want.bus_command, got.bus_command);
            check_field("write_strobe", want.write_strobe, got.write_strobe);
            check_field("write_byte", want.write_byte, got.write_byte);
            check_field("read_strobe", want.read_strobe, got.read_strobe);
            check_field("transmit_dir", want.transmit_dir, got.transmit_dir);
            check_field("nack_next", want.nack_next, got.nack_next);
            check_field("rx_valid", want.rx_valid, got.rx_valid);
            check_field("rx_byte", want.rx_byte, got.rx_byte);
            check_field("rx_index", want.rx_index, got.rx_index);
        endfunction
    endclass

endpackage

// ----- tb/sv/i2c_master_register_transaction_test.sv -----
`timescale 1ns / 1ps

module i2c_master_register_transaction_test;

    import i2cm_pkg::*;
    import i2cm_reply_check_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 1000;

    logic clk;
    logic rst_n;
    bit   no_gaps;
    int   words_sent;

    transaction_scoreboard sb = new();

    i2cm_in_if  in_ch ();
    i2cm_out_if out_ch ();

    i2c_master_register_transaction dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic in_word_t rand_word();
        in_word_t w;
        w.operation        = 2'($urandom_range(0, 2));
        w.buffer_index     = 8'($urandom);
        w.buffer_byte      = 8'($urandom);
        w.device_address   = 7'($urandom);
        w.register_address = 8'($urandom);
        w.length           = 8'($urandom);
        w.read_mode        = 1'($urandom);
        w.ack_missing      = 1'($urandom);
        w.data_in          = 8'($urandom);
        return w;
    endfunction

    function automatic in_word_t load_word(logic [7:0] idx, logic [7:0] data);
        in_word_t w;
        w              = rand_word();
        w.operation    = OP_LOAD;
        w.buffer_index = idx;
        w.buffer_byte  = data;
        return w;
    endfunction

    function automatic in_word_t start_word(logic [6:0] saddr, logic [7:0] raddr,
                                            logic [7:0] len, logic rmode);
        in_word_t w;
        w                  = rand_word();
        w.operation        = OP_START;
        w.device_address   = saddr;
        w.register_address = raddr;
        w.length           = len;
        w.read_mode        = rmode;
        return w;
    endfunction

    function automatic in_word_t event_word(logic nak, logic [7:0] din);
        in_word_t w;
        w             = rand_word();
        w.operation   = OP_EVENT;
        w.ack_missing = nak;
        w.data_in     = din;
        return w;
    endfunction

    task automatic drive_word(in_word_t w);
        int gap;
        in_ch.valid            <= 1'b1;
        in_ch.operation        <= w.operation;
        in_ch.buffer_index     <= w.buffer_index;
        in_ch.buffer_byte      <= w.buffer_byte;
        in_ch.device_address   <= w.device_address;
        in_ch.register_address <= w.register_address;
        in_ch.length           <= w.length;
        in_ch.read_mode        <= w.read_mode;
        in_ch.ack_missing      <= w.ack_missing;
        in_ch.data_in          <= w.data_in;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        sb.note_word(w);
        words_sent++;
        gap = gap_len();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // never let the block transmit a buffer entry nobody wrote
    task automatic send(in_word_t w);
        if (sb.needs_fill(w))
            drive_word(load_word(sb.position, 8'($urandom)));
        drive_word(w);
    endtask

    initial
    begin
        in_word_t w;
        int       pick;
        int       len;
        logic     rmode;
        rst_n                  <= 1'b0;
        in_ch.valid            <= 1'b0;
        in_ch.operation        <= OP_LOAD;
        in_ch.buffer_index     <= '0;
        in_ch.buffer_byte      <= '0;
        in_ch.device_address   <= '0;
        in_ch.register_address <= '0;
        in_ch.length           <= '0;
        in_ch.read_mode        <= 1'b0;
        in_ch.ack_missing      <= 1'b0;
        in_ch.data_in          <= '0;
        no_gaps    = 1'b0;
        words_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(load_word(8'd0, 8'hFF));
        send(load_word(8'd255, 8'h00));
        send(load_word(8'd1, 8'hA5));
        // register write of two bytes, then one event past completion
        send(start_word(7'h7F, 8'hFF, 8'd2, 1'b0));
        repeat (4) send(event_word(1'b0, 8'h00));
        send(event_word(1'b0, 8'hFF));
        // register read of two bytes
        send(start_word(7'h00, 8'h00, 8'd2, 1'b1));
        repeat (3) send(event_word(1'b0, 8'h00));
        send(event_word(1'b0, 8'hFF));
        send(event_word(1'b0, 8'h00));
        // event after read done sets up reception again, next one is past the length
        send(event_word(1'b0, 8'h5A));
        send(event_word(1'b0, 8'h3C));
        // zero length keeps the old settings; missing ack gives error
        send(start_word(7'h2A, 8'h11, 8'd0, 1'b0));
        send(event_word(1'b1, 8'h00));
        send(event_word(1'b1, 8'hFF));
        w           = rand_word();
        w.operation = OP_UNUSED;
        send(w);

        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            pick    = $urandom_range(0, 99);
            no_gaps = ($urandom_range(0, 6) == 0);
            if (pick < 70)
            begin
                len   = ($urandom_range(0, 29) == 0) ? $urandom_range(9, 255)
                                                     : $urandom_range(1, 8);
                rmode = 1'($urandom);
                if (!rmode)
                begin
                    for (int i = 0; i < len; i++)
                        if ($urandom_range(0, 1) == 1)
                            send(load_word(8'(i), 8'($urandom)));
                end
                send(start_word(7'($urandom), 8'($urandom), 8'(len), rmode));
                repeat (len + 3 + $urandom_range(0, 2))
                    send(event_word($urandom_range(0, 39) == 0, 8'($urandom)));
            end
            else if (pick < 80)
            begin
                send(start_word(7'($urandom), 8'($urandom), 8'd0, 1'($urandom)));
                repeat ($urandom_range(1, 6))
                    send(event_word($urandom_range(0, 9) == 0, 8'($urandom)));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    w           = rand_word();
                    w.operation = 2'($urandom_range(0, 3));
                    send(w);
                end
            end
        end
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // result side: check each accepted word and stall ready at random
    initial
    begin
        reply_t got;
        int     stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got.status       = out_ch.status;
                got.bus_command  = out_ch.bus_command;
                got.write_strobe = out_ch.write_strobe;
                got.write_byte   = out_ch.write_byte;
                got.read_strobe  = out_ch.read_strobe;
                got.transmit_dir = out_ch.transmit_dir;
                got.nack_next    = out_ch.nack_next;
                got.rx_valid     = out_ch.rx_valid;
                got.rx_byte      = out_ch.rx_byte;
                got.rx_index     = out_ch.rx_index;
                sb.check_reply(got);
            end
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                stall_left = gap_len();
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/i2cm_pkg.sv
design/i2cm_if.sv
design/i2cm_buffer.sv
design/i2cm_seq.sv
design/i2c_master_register_transaction.sv
tb/sv/i2cm_reply_check_pkg.sv
tb/sv/i2c_master_register_transaction_test.sv
